@@ src/ulca_pkg.sv @@
// Shared constants and control types for the serial line command assembler.
// No dependencies; imported by ulca_ctrl, ulca_dp and the top level.
package ulca_pkg;

    localparam int HALF_BYTES_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 5;

    localparam logic [BYTE_W-1:0] LF_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_CODE = 8'h0D;
    localparam logic [LEN_W-1:0]  MAX_CMD = 5'd31;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic start_read;
        logic read_empty;
        logic issue_rd;
        logic load_out;
    } ulca_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pend_nonempty;
        logic rd_last;
        logic out_free;
    } ulca_stat_t;

endpackage

@@ src/ulca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ulca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/ulca_ctrl.sv @@
// Sequencer for the line command assembler: accepts words, steps the read-out.
// Depends on ulca_pkg.
module ulca_ctrl
    import ulca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  ulca_stat_t stat,
    output ulca_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LD   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == ACT_READ) begin
                        if (stat.pend_nonempty) begin
                            cmd.start_read = 1'b1;
                            state_next     = ST_RD;
                        end else begin
                            cmd.read_empty = 1'b1;
                        end
                    end else begin
                        cmd.take_byte = 1'b1;
                    end
                end
            end
            ST_RD: begin
                if (stat.out_free) begin
                    cmd.issue_rd = 1'b1;
                    state_next   = ST_LD;
                end
            end
            ST_LD: begin
                cmd.load_out = 1'b1;
                state_next   = stat.rd_last ? ST_IDLE : ST_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/ulca_dp.sv @@
// Datapath: line counters, pending command, ping-pong store and output register.
// Depends on ulca_pkg and ulca_ram.
module ulca_dp
    import ulca_pkg::*;
#(
    parameter int HALF_BYTES = HALF_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] in_byte,
    input  ulca_cmd_t         cmd,
    output ulca_stat_t        stat,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic              m_tlast,
    output logic              m_tuser,
    output logic [BYTE_W-1:0] out_byte,
    output logic [LEN_W-1:0]  position,
    output logic [LEN_W-1:0]  command_length
);

    localparam int DEPTH  = 2 * HALF_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(HALF_BYTES + 1);
    localparam int CMP_W  = CNT_W + LEN_W;

    logic              write_half_reg, write_half_next;
    logic [CNT_W-1:0]  write_count_reg, write_count_next;
    logic              last_cr_reg, last_cr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic              rd_half_reg, rd_half_next;
    logic [LEN_W-1:0]  rd_len_reg, rd_len_next;
    logic [LEN_W-1:0]  rd_idx_reg, rd_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]  out_pos_reg, out_pos_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic [CNT_W-1:0]  line_len;
    logic              rd_last;

    assign rd_last = ({1'b0, rd_idx_reg} + 6'd1) == {1'b0, rd_len_reg};

    assign stat.pend_nonempty = pend_valid_reg && (pend_len_reg != '0);
    assign stat.rd_last       = rd_last;
    assign stat.out_free      = !out_valid_reg || m_tready;

    assign line_len  = write_count_reg
                     - CNT_W'((write_count_reg != '0) && last_cr_reg);
    assign mem_waddr = (write_half_reg ? ADDR_W'(HALF_BYTES) : '0)
                     + ADDR_W'(write_count_reg);
    assign mem_raddr = (rd_half_reg ? ADDR_W'(HALF_BYTES) : '0) + ADDR_W'(rd_idx_reg);

    always_comb begin
        write_half_next  = write_half_reg;
        write_count_next = write_count_reg;
        last_cr_next     = last_cr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_len_next    = pend_len_reg;
        rd_half_next     = rd_half_reg;
        rd_len_next      = rd_len_reg;
        rd_idx_next      = rd_idx_reg;
        mem_we           = 1'b0;

        if (cmd.take_byte) begin
            priority if (write_count_reg == CNT_W'(HALF_BYTES)) begin
                // full line: drop byte, restart same half
                write_count_next = '0;
            end else if (in_byte == LF_CODE) begin
                write_count_next = '0;
                if (CMP_W'(line_len) <= CMP_W'(MAX_CMD)) begin
                    pend_len_next   = LEN_W'(line_len);
                    pend_valid_next = 1'b1;
                    write_half_next = !write_half_reg;
                end
            end else begin
                mem_we           = 1'b1;
                write_count_next = write_count_reg + CNT_W'(1);
                last_cr_next     = (in_byte == CR_CODE);
            end
        end

        if (cmd.start_read) begin
            pend_valid_next = 1'b0;
            rd_half_next    = !write_half_reg;
            rd_len_next     = pend_len_reg;
            rd_idx_next     = '0;
        end
        if (cmd.read_empty) begin
            pend_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            rd_idx_next = rd_idx_reg + LEN_W'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_len_next   = out_len_reg;
        if (cmd.read_empty) begin
            out_valid_next = 1'b1;
            out_has_next   = 1'b0;
            out_last_next  = 1'b1;
            out_byte_next  = '0;
            out_pos_next   = '0;
            out_len_next   = '0;
        end else if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_has_next   = 1'b1;
            out_last_next  = rd_last;
            out_byte_next  = mem_rdata;
            out_pos_next   = rd_idx_reg;
            out_len_next   = rd_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_half_reg  <= 1'b0;
            write_count_reg <= '0;
            last_cr_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_len_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            write_half_reg  <= write_half_next;
            write_count_reg <= write_count_next;
            last_cr_reg     <= last_cr_next;
            pend_valid_reg  <= pend_valid_next;
            pend_len_reg    <= pend_len_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_half_reg  <= rd_half_next;
        rd_len_reg   <= rd_len_next;
        rd_idx_reg   <= rd_idx_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_len_reg  <= out_len_next;
    end

    ulca_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_byte),
        .re    (cmd.issue_rd),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid       = out_valid_reg;
    assign m_tlast        = out_last_reg;
    assign m_tuser        = out_has_reg;
    assign out_byte       = out_byte_reg;
    assign position       = out_pos_reg;
    assign command_length = out_len_reg;

endmodule

@@ src/uart_line_command_assembler_top.sv @@
// Serial line command assembler: top level joining sequencer and datapath.
// Depends on ulca_pkg, ulca_ctrl, ulca_dp (and ulca_ram below it).
//
// Input stream: s_tuser selects the action (0 = received byte, 1 = read the
// pending command), s_tdata carries the byte. Received bytes fill one half of
// a ping-pong line store; a line feed closes the line (a trailing carriage
// return is not counted) and makes it the pending command. A line that fills
// its half is thrown away on the next byte, pending command untouched.
// Result stream: a read returns the pending command one word per byte, with
// tlast on the final one, or a single empty word (tuser low) if none pends or it has no bytes.
// A byte word gives no result. A read returns each byte by a RAM read, then
// an output register load; the empty reply is ready the cycle after
// acceptance.
// s_tready is low while a read-out runs and while the output register holds
// a word the receiver has not taken; a stall on m_tready pauses the read-out.
// Reset: no pending command, first half selected, line empty; store contents
// are undefined until written.
module uart_line_command_assembler_top
    import ulca_pkg::*;
#(
    parameter int HALF_BYTES = HALF_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [12:8] position,
                                   // [17:13] command_length, [23:18] zero
    output logic        m_tuser,   // [0] has_command
    output logic        m_tlast    // last
);

    ulca_cmd_t         cmd;
    ulca_stat_t        stat;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  position;
    logic [LEN_W-1:0]  command_length;

    ulca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ulca_dp #(
        .HALF_BYTES(HALF_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_byte        (s_tdata),
        .cmd            (cmd),
        .stat           (stat),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .out_byte       (out_byte),
        .position       (position),
        .command_length (command_length)
    );

    assign m_tdata = {6'd0, command_length, position, out_byte};

endmodule

@@ src/ulca_checker.sv @@
// Port-level checks for the serial line command assembler, bound to the top.
// Depends on uart_line_command_assembler_top.
module ulca_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 24'd0))
        else $error("empty reply malformed");

    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[12:8] < m_tdata[17:13]))
        else $error("position beyond command length");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tlast == ((m_tdata[12:8] + 5'd1) == m_tdata[17:13])))
        else $error("last marker misplaced");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast |=> !s_tready)
        else $error("input taken during read-out");

endmodule

bind uart_line_command_assembler_top ulca_checker u_ulca_checker (.*);
